// ----- hw/rtl/fpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fpsd_pkg: shared definitions for the frame plane shuffle delay
// Default sizes, register indexes, effect modes and the small pick tables.
// ----------------------------------------------------------------------------
package fpsd_pkg;

    localparam int PLANE_COUNT_DEF      = 32;
    localparam int FRAME_PIXELS_MAX_DEF = 16384;

    localparam int PIXEL_W        = 32;
    localparam int FRAME_PIXELS_W = 15;
    localparam int RAND_PLANE_W   = 5;
    localparam int RAND_STEP_W    = 3;
    localparam int RAND_LEN_W     = 3;
    localparam int IN_TDATA_W     = 48;
    localparam int STEP_CODES     = 5;

    localparam logic [FRAME_PIXELS_W-1:0] FRAME_PIXELS_RST = 15'd16384;

    typedef enum logic [0:0] {
        CFG_EFFECT_MODE  = 1'b0,
        CFG_FRAME_PIXELS = 1'b1
    } t_cfg_index;

    typedef enum logic [0:0] {
        MODE_RANDOM  = 1'b0,
        MODE_SCRATCH = 1'b1
    } t_effect_mode;

    // random stride pick reduced modulo the five stride codes
    localparam logic [RAND_STEP_W-1:0] STEP_CODE_MAP [8] =
        '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd1, 3'd2};

    // random run pick reduced modulo six, plus two frames
    localparam logic [2:0] RUN_LEN_MAP [8] =
        '{3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd2, 3'd3};

endpackage

// ----- hw/rtl/frame_plane_shuffle_delay.sv -----
// ----------------------------------------------------------------------------
// frame_plane_shuffle_delay: random frame delay video effect
// Writes each frame into a ring of plane stores and plays out pixels from a
// plane picked at every frame start.
// ----------------------------------------------------------------------------
// The block takes one pixel item per clock while the output is not stalled
// and returns one item per pixel through a read stage and an output
// register. That rate is set by the plane store: a single RAM with one write
// port and one read port, each used at most once per item (write the pixel
// into the current write plane, read the same position from the read plane).
// The store holds PLANE_COUNT x 2**clog2(FRAME_PIXELS_MAX) words of 32 bits
// and needs no clearing pass after reset: planes that were never written are
// never read, the block reads plane 0 in their place. When the read plane is
// the plane being written the input pixel is forwarded. effect_mode and the
// random fields of the input are sampled on the first pixel of each frame;
// frame_pixels is checked on every pixel. Write configuration only while no
// item is in flight.
// ----------------------------------------------------------------------------
module frame_plane_shuffle_delay
    import fpsd_pkg::*;
#(
    parameter int PLANE_COUNT      = PLANE_COUNT_DEF,
    parameter int FRAME_PIXELS_MAX = FRAME_PIXELS_MAX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration write port
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_addr,
    input  logic [FRAME_PIXELS_W-1:0] i_cfg_data,
    // input stream
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // tdata: pixel_in[31:0], rand_plane[36:32], rand_step[39:37],
    //        rand_length[42:40], zero[47:43]
    input  logic [IN_TDATA_W-1:0]     i_s_axis_tdata,
    // output stream
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // tdata: pixel_out[31:0]
    output logic [PIXEL_W-1:0]        o_m_axis_tdata,
    output logic                      o_m_axis_tlast   // frame_end
);

    localparam int PW    = $clog2(PLANE_COUNT);
    localparam int IDXW  = $clog2(FRAME_PIXELS_MAX);
    localparam int NW    = (IDXW + 1 > FRAME_PIXELS_W) ? IDXW + 1 : FRAME_PIXELS_W;
    localparam int DEPTH = PLANE_COUNT * (2 ** IDXW);

    localparam logic [NW-1:0]   FRAME_MAX_N = NW'(FRAME_PIXELS_MAX);
    localparam logic [PW:0]     PLANE_N     = (PW + 1)'(PLANE_COUNT);
    localparam logic [PW-1:0]   PLANE_LAST  = PW'(PLANE_COUNT - 1);

    // ---------------------------------------------------------------- config
    t_effect_mode              r_effect_mode;
    logic [FRAME_PIXELS_W-1:0] r_frame_pixels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_effect_mode  <= MODE_RANDOM;
            r_frame_pixels <= FRAME_PIXELS_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_addr))
                CFG_EFFECT_MODE:  r_effect_mode  <= t_effect_mode'(i_cfg_data[0]);
                CFG_FRAME_PIXELS: r_frame_pixels <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // --------------------------------------------------------- pick tables
    // Reduce the random plane modulo the ring size, and map each stride code
    // to the forward distance that gives the same plane after wraparound.
    logic [PW-1:0] w_plane_mod [32];
    logic [PW-1:0] w_step_add  [STEP_CODES];

    for (genvar g = 0; g < 32; g++) begin : g_plane_mod
        assign w_plane_mod[g] = PW'(g % PLANE_COUNT);
    end

    for (genvar c = 0; c < STEP_CODES; c++) begin : g_step_add
        localparam int STRIDE = (c < 2) ? c - 2 : c - 1;
        assign w_step_add[c] = PW'((PLANE_COUNT + STRIDE) % PLANE_COUNT);
    end

    // ----------------------------------------------------------- handshake
    logic w_accept;
    logic w_s1_adv;
    logic r_s1_valid;
    logic r_out_valid;

    assign w_s1_adv        = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || w_s1_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // --------------------------------------------------------- item fields
    logic [PIXEL_W-1:0]      w_pix;
    logic [RAND_PLANE_W-1:0] w_rand_plane;
    logic [RAND_STEP_W-1:0]  w_rand_step;
    logic [RAND_LEN_W-1:0]   w_rand_len;

    assign w_pix        = i_s_axis_tdata[31:0];
    assign w_rand_plane = i_s_axis_tdata[36:32];
    assign w_rand_step  = i_s_axis_tdata[39:37];
    assign w_rand_len   = i_s_axis_tdata[42:40];

    // --------------------------------------------------------- frame state
    logic [PLANE_COUNT-1:0] r_filled,      n_filled;
    logic [PW-1:0]          r_write_plane, n_write_plane;
    logic [PW-1:0]          r_read_plane,  n_read_plane;
    logic [RAND_STEP_W-1:0] r_scr_step,    n_scr_step;
    logic [2:0]             r_scr_left,    n_scr_left;
    logic [IDXW-1:0]        r_pix_idx,     n_pix_idx;

    logic          w_first;
    logic [PW:0]   w_step_sum;
    logic [PW-1:0] w_src;
    logic          w_fwd;
    logic [NW-1:0] w_frame_n;
    logic [NW-1:0] w_idx_next;
    logic          w_last;

    always_comb begin
        n_filled     = r_filled;
        n_read_plane = r_read_plane;
        n_scr_step   = r_scr_step;
        n_scr_left   = r_scr_left;
        w_first      = (r_pix_idx == '0);
        w_step_sum   = {1'b0, r_read_plane} + {1'b0, w_step_add[r_scr_step]};

        // Pick the read plane on the first pixel of a frame; mark the
        // write plane filled at the same time.
        if (w_first) begin
            n_filled[r_write_plane] = 1'b1;
            if (r_effect_mode == MODE_RANDOM) begin
                n_read_plane = w_plane_mod[w_rand_plane];
            end else if (r_scr_left != 3'd0) begin
                n_read_plane = (w_step_sum >= PLANE_N) ? PW'(w_step_sum - PLANE_N)
                                                       : w_step_sum[PW-1:0];
                n_scr_left   = r_scr_left - 3'd1;
            end else begin
                n_read_plane = w_plane_mod[w_rand_plane];
                n_scr_step   = STEP_CODE_MAP[w_rand_step];
                n_scr_left   = RUN_LEN_MAP[w_rand_len];
            end
        end

        // Unwritten planes read as plane 0; forward when reading the
        // plane being written.
        w_src = n_filled[n_read_plane] ? n_read_plane : '0;
        w_fwd = (w_src == r_write_plane);

        // Clamp the configured frame size to 1..FRAME_PIXELS_MAX.
        if (r_frame_pixels == '0) begin
            w_frame_n = NW'(1);
        end else if (NW'(r_frame_pixels) > FRAME_MAX_N) begin
            w_frame_n = FRAME_MAX_N;
        end else begin
            w_frame_n = NW'(r_frame_pixels);
        end

        w_idx_next = NW'(r_pix_idx) + NW'(1);
        w_last     = (w_idx_next >= w_frame_n);

        if (w_last) begin
            n_pix_idx     = '0;
            n_write_plane = (r_write_plane == PLANE_LAST) ? '0 : r_write_plane + PW'(1);
        end else begin
            n_pix_idx     = w_idx_next[IDXW-1:0];
            n_write_plane = r_write_plane;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filled      <= '0;
            r_write_plane <= '0;
            r_read_plane  <= '0;
            r_scr_step    <= '0;
            r_scr_left    <= '0;
            r_pix_idx     <= '0;
        end else if (w_accept) begin
            r_filled      <= n_filled;
            r_write_plane <= n_write_plane;
            r_read_plane  <= n_read_plane;
            r_scr_step    <= n_scr_step;
            r_scr_left    <= n_scr_left;
            r_pix_idx     <= n_pix_idx;
        end
    end

    // --------------------------------------------------------- plane store
    // Write and read never hit the same entry in one cycle: a read of the
    // write plane is replaced by forwarding.
    logic [PIXEL_W-1:0] w_rdata;

    fpsd_ram #(
        .DATA_W (PIXEL_W),
        .DEPTH  (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr ({r_write_plane, r_pix_idx}),
        .i_wdata (w_pix),
        .i_re    (w_accept && !w_fwd),
        .i_raddr ({w_src, r_pix_idx}),
        .o_rdata (w_rdata)
    );

    // ------------------------------------------------ read stage and output
    logic [PIXEL_W-1:0] r_s1_pix;
    logic               r_s1_fwd;
    logic               r_s1_last;
    logic [PIXEL_W-1:0] r_out_pixel;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Hold the item in the read stage while the output is stalled; the RAM
    // read data holds too since no new read is issued.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pix  <= w_pix;
            r_s1_fwd  <= w_fwd;
            r_s1_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_pixel <= r_s1_fwd ? r_s1_pix : w_rdata;
            r_out_last  <= r_s1_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_pixel;
    assign o_m_axis_tlast  = r_out_last;

    // ----------------------------------------------------------- assertions
`ifndef ASSERT_OFF
    a_read_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_read_plane} < PLANE_N)
        else $error("read plane outside the ring");

    a_write_plane_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_write_plane} < PLANE_N)
        else $error("write plane outside the ring");

    a_step_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scr_step < RAND_STEP_W'(STEP_CODES))
        else $error("stride code out of range");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |=> (r_pix_idx == '0))
        else $error("pixel index did not wrap at frame end");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && $stable(r_s1_pix)))
        else $error("stalled read stage lost its item");
`endif

endmodule

// ----- hw/rtl/fpsd_ram.sv -----
// ----------------------------------------------------------------------------
// fpsd_ram: simple dual-port plane store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpsd_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
